// ===== hw/rtl/vhcs_pkg.sv =====
// Shared types and constants for the voxel file header chunk scanner.
// No dependencies; imported by every module of the block.
package vhcs_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_word_type;

   typedef struct packed {
      logic        header_ok;
      logic [7:0]  size_x;
      logic [7:0]  size_y;
      logic [7:0]  size_z;
      logic [15:0] voxel_count;
   } rsp_word_type;

   typedef enum logic [5:0] {
      PH_FILEHDR = 6'b000001,
      PH_SKIP    = 6'b000010,
      PH_CHUNK   = 6'b000100,
      PH_SIZE    = 6'b001000,
      PH_XYZI    = 6'b010000,
      PH_STOP    = 6'b100000
   } phase_type;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DIM    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_VOXELS = 1'b1;

   localparam logic [7:0]  MAX_DIM_RESET    = 8'd255;
   localparam logic [15:0] MAX_VOXELS_RESET = 16'd65535;

   localparam logic [31:0] TAG_VOX  = 32'h2058_4F56;
   localparam logic [31:0] TAG_MAIN = 32'h4E49_414D;
   localparam logic [31:0] TAG_SIZE = 32'h455A_4953;
   localparam logic [31:0] TAG_XYZI = 32'h495A_5958;

   localparam logic [31:0] VERSION_MIN  = 32'd100;
   localparam logic [31:0] VERSION_MAX  = 32'd250;
   localparam logic [31:0] SIZE_CONTENT = 32'd12;
   localparam logic [31:0] XYZI_CONTENT = 32'd4;

   localparam int FIELD_W = 4;
   localparam logic [FIELD_W-1:0] WORD0_END = 4'd3;
   localparam logic [FIELD_W-1:0] WORD1_END = 4'd7;
   localparam logic [FIELD_W-1:0] WORD2_END = 4'd11;
   localparam logic [FIELD_W-1:0] WORD3_END = 4'd15;

endpackage

// ===== hw/rtl/vhcs_in_stage.sv =====
// Input register for the scanner: holds one request word until the parser takes it.
// Depends on vhcs_pkg.
module vhcs_in_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  vhcs_pkg::req_word_type req_word,
   output logic                  req_ready,
   input  logic                  pop,
   output logic                  held_valid,
   output vhcs_pkg::req_word_type held_word
);
   import vhcs_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   req_word_type word_ff;
   logic         accept;

   assign req_ready = !valid_ff || pop;
   assign accept    = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         word_ff <= req_word;
      end
   end

   assign held_valid = valid_ff;
   assign held_word  = word_ff;

endmodule

// ===== hw/rtl/vhcs_parser.sv =====
// Byte-wise header and chunk walker with registered state: one byte per step.
// Depends on vhcs_pkg.
module vhcs_parser #(
   parameter int WINDOW_BYTES = 512
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  vhcs_pkg::req_word_type word,
   input  logic [7:0]             max_dim,
   input  logic [15:0]            max_voxels,
   output logic                   emit,
   output vhcs_pkg::rsp_word_type result
);
   import vhcs_pkg::*;

   localparam int POS_W = $clog2(WINDOW_BYTES + 1);
   localparam logic [POS_W-1:0] WINDOW_END = POS_W'(WINDOW_BYTES);

   phase_type          phase_ff, phase_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [FIELD_W-1:0] field_ff, field_in;
   logic [31:0]        acc_ff, acc_in;
   logic [31:0]        tag_ff, tag_in;
   logic [31:0]        len_ff, len_in;
   logic [32:0]        skip_ff, skip_in;
   logic               seen_ff, seen_in;
   logic [2:0][7:0]    pend_ff, pend_in;
   logic [2:0][7:0]    dims_ff, dims_in;
   logic [15:0]        count_ff, count_in;
   logic               ok_ff, ok_in;
   logic               clear;

   always_comb begin
      logic [31:0] w;
      logic [32:0] skip_new;
      logic        word_done;

      phase_in = phase_ff;
      pos_in   = pos_ff;
      field_in = field_ff;
      acc_in   = acc_ff;
      tag_in   = tag_ff;
      len_in   = len_ff;
      skip_in  = skip_ff;
      seen_in  = seen_ff;
      pend_in  = pend_ff;
      dims_in  = dims_ff;
      count_in = count_ff;
      ok_in    = ok_ff;

      w         = {word.data_byte, acc_ff[31:8]};
      word_done = (field_ff[1:0] == 2'b11);
      skip_new  = '0;

      if (step && (pos_ff < WINDOW_END)) begin
         pos_in = pos_ff + POS_W'(1);
         case (phase_ff)
            PH_SKIP: begin
               skip_in = skip_ff - 33'd1;
               if (skip_in == '0) begin
                  field_in = '0;
                  phase_in = PH_CHUNK;
               end
            end
            PH_FILEHDR: begin
               acc_in   = w;
               field_in = field_ff + FIELD_W'(1);
               if (word_done) begin
                  if (field_ff == WORD0_END) begin
                     if (w != TAG_VOX) phase_in = PH_STOP;
                  end else if (field_ff == WORD1_END) begin
                     if (!(w inside {[VERSION_MIN:VERSION_MAX]})) phase_in = PH_STOP;
                  end else if (field_ff == WORD2_END) begin
                     if (w != TAG_MAIN) phase_in = PH_STOP;
                  end else begin
                     skip_in  = {1'b0, w};
                     field_in = '0;
                     phase_in = (w == '0) ? PH_CHUNK : PH_SKIP;
                  end
               end
            end
            PH_CHUNK: begin
               acc_in   = w;
               field_in = field_ff + FIELD_W'(1);
               if (word_done) begin
                  if (field_ff == WORD0_END) begin
                     tag_in = w;
                  end else if (field_ff == WORD1_END) begin
                     len_in = w;
                  end else if (!seen_ff && (tag_ff == TAG_SIZE)) begin
                     if (len_ff < SIZE_CONTENT) begin
                        phase_in = PH_STOP;
                     end else begin
                        skip_in  = {1'b0, len_ff - SIZE_CONTENT} + {1'b0, w};
                        field_in = '0;
                        pend_in  = '0;
                        phase_in = PH_SIZE;
                     end
                  end else if (tag_ff == TAG_XYZI) begin
                     if (len_ff < XYZI_CONTENT) begin
                        phase_in = PH_STOP;
                     end else begin
                        field_in = '0;
                        phase_in = PH_XYZI;
                     end
                  end else begin
                     skip_new = {1'b0, len_ff} + {1'b0, w};
                     skip_in  = skip_new;
                     field_in = '0;
                     phase_in = (skip_new == '0) ? PH_CHUNK : PH_SKIP;
                  end
               end
            end
            PH_SIZE: begin
               acc_in   = w;
               field_in = field_ff + FIELD_W'(1);
               if (word_done) begin
                  if ((w == '0) || (w > {24'd0, max_dim})) begin
                     phase_in = PH_STOP;
                  end else begin
                     pend_in[field_ff[3:2]] = w[7:0];
                     if (field_ff == WORD2_END) begin
                        dims_in  = pend_in;
                        seen_in  = 1'b1;
                        field_in = '0;
                        phase_in = (skip_ff == '0) ? PH_CHUNK : PH_SKIP;
                     end
                  end
               end
            end
            PH_XYZI: begin
               acc_in   = w;
               field_in = field_ff + FIELD_W'(1);
               if (word_done) begin
                  if (w <= {16'd0, max_voxels}) begin
                     count_in = w[15:0];
                     ok_in    = seen_ff;
                  end
                  phase_in = PH_STOP;
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign clear = step && word.last_byte;
   assign emit  = clear;

   assign result.header_ok   = ok_in;
   assign result.size_x      = dims_in[0];
   assign result.size_y      = dims_in[1];
   assign result.size_z      = dims_in[2];
   assign result.voxel_count = count_in;

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         phase_ff <= PH_FILEHDR;
         pos_ff   <= '0;
         field_ff <= '0;
         seen_ff  <= 1'b0;
         dims_ff  <= '0;
         count_ff <= '0;
         ok_ff    <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         field_ff <= field_in;
         seen_ff  <= seen_in;
         dims_ff  <= dims_in;
         count_ff <= count_in;
         ok_ff    <= ok_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      tag_ff  <= tag_in;
      len_ff  <= len_in;
      skip_ff <= skip_in;
      pend_ff <= pend_in;
   end

endmodule

// ===== hw/rtl/vhcs_out_stage.sv =====
// Result register: holds one response word until the consumer takes it.
// Depends on vhcs_pkg.
module vhcs_out_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  vhcs_pkg::rsp_word_type load_word,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output vhcs_pkg::rsp_word_type rsp_word
);
   import vhcs_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   rsp_word_type word_ff;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= load_word;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_word  = word_ff;

endmodule

// ===== hw/rtl/vox_header_chunk_scanner_top.sv =====
// Voxel file header chunk scanner, top level: input register, parser, result register.
// The result word of a last byte passes the input register, then the result register.
// Throughput: one byte per cycle; a last byte waits only while an unread result is held.
// Reset (synchronous, active high) returns the parser to the file header, clears both
// handshake stages and restores max_dim to 255 and max_voxels to 65535.
module vox_header_chunk_scanner_top #(
   parameter int WINDOW_BYTES = 512
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  vhcs_pkg::req_word_type            req_word,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output vhcs_pkg::rsp_word_type            rsp_word,
   input  logic                              csr_wr_en,
   input  logic [vhcs_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [vhcs_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import vhcs_pkg::*;

   logic [7:0]   max_dim_ff;
   logic [15:0]  max_voxels_ff;
   logic         held_valid;
   req_word_type held_word;
   logic         take;
   logic         emit;
   rsp_word_type result;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_dim_ff    <= MAX_DIM_RESET;
         max_voxels_ff <= MAX_VOXELS_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_MAX_DIM:    max_dim_ff    <= csr_wdata[7:0];
            CSR_MAX_VOXELS: max_voxels_ff <= csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   assign take = held_valid && (!held_word.last_byte || !rsp_valid || rsp_ready);

   vhcs_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_word   (req_word),
      .req_ready  (req_ready),
      .pop        (take),
      .held_valid (held_valid),
      .held_word  (held_word)
   );

   vhcs_parser #(
      .WINDOW_BYTES (WINDOW_BYTES)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .step       (take),
      .word       (held_word),
      .max_dim    (max_dim_ff),
      .max_voxels (max_voxels_ff),
      .emit       (emit),
      .result     (result)
   );

   vhcs_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (emit),
      .load_word (result),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

`ifndef SYNTHESIS
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      !(emit && rsp_valid && !rsp_ready))
      else $error("result register overwritten while held");

   a_ok_has_dims: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.header_ok) |->
      (rsp_word.size_x != 8'd0 && rsp_word.size_y != 8'd0 && rsp_word.size_z != 8'd0))
      else $error("header_ok without accepted dimensions");

   a_dims_together: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.size_x == 8'd0) |->
      (rsp_word.size_y == 8'd0 && rsp_word.size_z == 8'd0))
      else $error("partial dimensions reported");

   a_emit_needs_last: assert property (@(posedge clock) disable iff (reset)
      emit |-> (held_valid && held_word.last_byte))
      else $error("result produced without a last byte");
`endif

endmodule

// ===== bench/tb_vox_header_chunk_scanner_top.sv =====
`timescale 1ns / 100ps
// Testbench for vox_header_chunk_scanner_top (needs vhcs_pkg and the RTL): builds voxel file
// byte streams, checks each end-of-file result against a typed case or a built-in scanner.
module tb_vox_header_chunk_scanner_top;
   import vhcs_pkg::*;

   localparam int SCAN_WINDOW = 512;
   localparam int STALL_LIMIT = 4000;
   localparam int HOLD_CYCLES = 400;
   localparam int FILL_CAP    = 490;
   localparam rsp_word_type NO_HEADER = '0;

   typedef struct {
      logic [7:0]   lim_dim;
      logic [15:0]  lim_vox;
      logic [31:0]  magic;
      logic [31:0]  version;
      logic [31:0]  main_tag;
      int           main_len;
      bit           pad;
      logic [31:0]  pad_clen;
      logic [31:0]  pad_child;
      logic [31:0]  size_clen;
      logic [31:0]  dim_x;
      logic [31:0]  dim_y;
      logic [31:0]  dim_z;
      logic [31:0]  xyzi_clen;
      logic [31:0]  count;
      bit           xyzi_first;
      bit           size_twice;
      int           cut;
      bit           typed;
      rsp_word_type outcome;
   } file_spec_type;

   typedef struct {
      bit           typed;
      rsp_word_type outcome;
   } file_outcome_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_word_type          req_word;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_word_type          rsp_word;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   vox_header_chunk_scanner_top #(.WINDOW_BYTES(SCAN_WINDOW)) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // columns: max_dim, max_voxels, magic, version, main tag, main length,
   //          pad chunk, pad content, pad children, SIZE length, x, y, z,
   //          XYZI length, count, XYZI first, second SIZE, cut, typed, outcome
   file_spec_type header_cases [24] = '{
      '{255, 65535, TAG_VOX, 150, TAG_MAIN, 0, 0, 0, 0,
        12, 1, 2, 3, 4, 7, 0, 0, 1, 1, NO_HEADER},
      '{255, 65535, TAG_VOX, 100, TAG_MAIN, 0, 0, 0, 0,
        12, 1, 2, 3, 4, 7, 0, 0, 0, 1, '{1, 1, 2, 3, 7}},
      '{255, 65535, TAG_VOX, 250, TAG_MAIN, 0, 0, 0, 0,
        12, 255, 255, 255, 4, 65535, 0, 0, 0, 1, '{1, 255, 255, 255, 65535}},
      '{255, 65535, TAG_VOX, 99, TAG_MAIN, 0, 0, 0, 0,
        12, 1, 2, 3, 4, 7, 0, 0, 0, 1, NO_HEADER},
      '{255, 65535, TAG_VOX, 251, TAG_MAIN, 0, 0, 0, 0,
        12, 1, 2, 3, 4, 7, 0, 0, 0, 1, NO_HEADER},
      '{255, 65535, TAG_VOX, 32'hFFFF_FFFF, TAG_MAIN, 0, 0, 0, 0,
        12, 1, 2, 3, 4, 7, 0, 0, 0, 1, NO_HEADER},
      '{255, 65535, 32'h2058_4F57, 150, TAG_MAIN, 0, 0, 0, 0,
        12, 1, 2, 3, 4, 7, 0, 0, 0, 1, NO_HEADER},
      '{255, 65535, TAG_VOX, 150, 32'h4E49_414E, 0, 0, 0, 0,
        12, 1, 2, 3, 4, 7, 0, 0, 0, 1, NO_HEADER},
      '{255, 65535, TAG_VOX, 150, TAG_MAIN, 0, 0, 0, 0,
        11, 1, 2, 3, 4, 7, 0, 0, 0, 1, NO_HEADER},
      '{255, 65535, TAG_VOX, 150, TAG_MAIN, 0, 0, 0, 0,
        12, 1, 0, 3, 4, 7, 0, 0, 0, 1, NO_HEADER},
      '{255, 65535, TAG_VOX, 150, TAG_MAIN, 0, 0, 0, 0,
        12, 1, 2, 256, 4, 7, 0, 0, 0, 1, NO_HEADER},
      '{255, 65535, TAG_VOX, 150, TAG_MAIN, 0, 0, 0, 0,
        12, 4, 5, 6, 3, 7, 0, 0, 0, 1, '{0, 4, 5, 6, 0}},
      '{255, 65535, TAG_VOX, 150, TAG_MAIN, 0, 0, 0, 0,
        12, 1, 2, 3, 4, 9, 1, 0, 0, 1, '{0, 0, 0, 0, 9}},
      '{255, 65535, TAG_VOX, 180, TAG_MAIN, 5, 1, 3, 5,
        14, 9, 8, 7, 6, 300, 0, 1, 0, 0, NO_HEADER},
      '{255, 65535, TAG_VOX, 150, TAG_MAIN, 0, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
        12, 1, 2, 3, 4, 7, 0, 0, 0, 1, NO_HEADER},
      '{255, 65535, TAG_VOX, 150, TAG_MAIN, 456, 0, 0, 0,
        12, 10, 20, 30, 4, 40, 0, 0, 0, 0, NO_HEADER},
      '{255, 65535, TAG_VOX, 150, TAG_MAIN, 457, 0, 0, 0,
        12, 10, 20, 30, 4, 40, 0, 0, 0, 0, NO_HEADER},
      '{255, 65535, TAG_VOX, 150, TAG_MAIN, 470, 0, 0, 0,
        12, 10, 20, 30, 4, 40, 0, 0, 0, 0, NO_HEADER},
      '{1, 0, TAG_VOX, 150, TAG_MAIN, 0, 0, 0, 0,
        12, 1, 1, 1, 4, 0, 0, 0, 0, 1, '{1, 1, 1, 1, 0}},
      '{1, 0, TAG_VOX, 150, TAG_MAIN, 0, 0, 0, 0,
        12, 1, 2, 1, 4, 0, 0, 0, 0, 1, NO_HEADER},
      '{1, 0, TAG_VOX, 150, TAG_MAIN, 0, 0, 0, 0,
        12, 1, 1, 1, 4, 1, 0, 0, 0, 1, '{0, 1, 1, 1, 0}},
      '{200, 1000, TAG_VOX, 150, TAG_MAIN, 0, 0, 0, 0,
        12, 200, 199, 1, 4, 1000, 0, 0, 0, 1, '{1, 200, 199, 1, 1000}},
      '{200, 1000, TAG_VOX, 150, TAG_MAIN, 0, 0, 0, 0,
        12, 5, 6, 7, 4, 8, 0, 0, 30, 0, NO_HEADER},
      '{255, 65535, TAG_VOX, 150, TAG_MAIN, 0, 0, 0, 0,
        12, 1, 2, 3, 4, 32'h0001_0000, 0, 0, 0, 1, '{0, 1, 2, 3, 0}}
   };

   logic [7:0]       cfg_dim;
   logic [15:0]      cfg_vox;
   phase_type        scan_phase;
   int unsigned      scan_pos;
   int unsigned      scan_idx;
   logic [31:0]      scan_acc;
   logic [31:0]      scan_tag;
   logic [31:0]      scan_clen;
   logic [32:0]      scan_skip;
   bit               scan_size_seen;
   logic [23:0]      scan_dims_pend;
   logic [23:0]      scan_dims;
   logic [15:0]      scan_count;
   bit               scan_ok;

   rsp_word_type     pending_results[$];
   file_outcome_type file_outcomes[$];
   logic [7:0]       file_bytes[$];
   int unsigned      fail_count;
   int unsigned      sent_bytes;
   int unsigned      stall_cycles;
   bit               hold_rsp;

   function void scan_clear();
      scan_phase     = PH_FILEHDR;
      scan_pos       = 0;
      scan_idx       = 0;
      scan_acc       = '0;
      scan_tag       = '0;
      scan_clen      = '0;
      scan_skip      = '0;
      scan_size_seen = 1'b0;
      scan_dims_pend = '0;
      scan_dims      = '0;
      scan_count     = '0;
      scan_ok        = 1'b0;
   endfunction

   function void scan_begin_skip();
      scan_idx   = 0;
      scan_phase = (scan_skip == 0) ? PH_CHUNK : PH_SKIP;
   endfunction

   function void scan_take(input logic [7:0] b);
      int unsigned idx;
      logic [31:0] w;
      if (scan_phase == PH_SKIP) begin
         scan_skip = scan_skip - 1'b1;
         if (scan_skip == 0) begin
            scan_idx   = 0;
            scan_phase = PH_CHUNK;
         end
         return;
      end
      if (scan_phase == PH_STOP)
         return;
      idx      = scan_idx;
      scan_acc = {b, scan_acc[31:8]};
      scan_idx = idx + 1;
      if (idx[1:0] != 2'd3)
         return;
      w = scan_acc;
      case (scan_phase)
         PH_FILEHDR: begin
            if (idx == 3 && w != TAG_VOX)
               scan_phase = PH_STOP;
            else if (idx == 7 && (w < VERSION_MIN || w > VERSION_MAX))
               scan_phase = PH_STOP;
            else if (idx == 11 && w != TAG_MAIN)
               scan_phase = PH_STOP;
            else if (idx == 15) begin
               scan_skip = {1'b0, w};
               scan_begin_skip();
            end
         end
         PH_CHUNK: begin
            if (idx == 3)
               scan_tag = w;
            else if (idx == 7)
               scan_clen = w;
            else if (!scan_size_seen && scan_tag == TAG_SIZE) begin
               if (scan_clen < SIZE_CONTENT) begin
                  scan_phase = PH_STOP;
                  return;
               end
               scan_skip      = {1'b0, scan_clen - SIZE_CONTENT} + {1'b0, w};
               scan_idx       = 0;
               scan_dims_pend = '0;
               scan_phase     = PH_SIZE;
            end else if (scan_tag == TAG_XYZI) begin
               if (scan_clen < XYZI_CONTENT) begin
                  scan_phase = PH_STOP;
                  return;
               end
               scan_idx   = 0;
               scan_phase = PH_XYZI;
            end else begin
               scan_skip = {1'b0, scan_clen} + {1'b0, w};
               scan_begin_skip();
            end
         end
         PH_SIZE: begin
            if (w == 0 || w > {24'd0, cfg_dim}) begin
               scan_phase = PH_STOP;
               return;
            end
            scan_dims_pend[8 * idx[3:2] +: 8] = w[7:0];
            if (idx == 11) begin
               scan_dims      = scan_dims_pend;
               scan_size_seen = 1'b1;
               scan_begin_skip();
            end
         end
         default: begin
            if (w > {16'd0, cfg_vox}) begin
               scan_phase = PH_STOP;
               return;
            end
            scan_count = w[15:0];
            scan_ok    = scan_size_seen;
            scan_phase = PH_STOP;
         end
      endcase
   endfunction

   function void scan_byte(input logic [7:0] b, input bit last, output bit emit,
                           output rsp_word_type outcome);
      if (scan_pos < SCAN_WINDOW) begin
         scan_take(b);
         scan_pos++;
      end
      emit    = last;
      outcome = '{scan_ok, scan_dims[7:0], scan_dims[15:8], scan_dims[23:16], scan_count};
      if (last)
         scan_clear();
   endfunction

   task report_mismatch(input string what, input int unsigned got, input int unsigned want);
      $display("%0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      fail_count++;
   endtask

   task check_field(input string what, input int unsigned got, input int unsigned want);
      if (got != want)
         report_mismatch(what, got, want);
   endtask

   always @(posedge clock) begin : monitor
      bit               emit;
      rsp_word_type     outcome;
      file_outcome_type plan;
      if (!reset) begin
         if (req_valid && req_ready) begin
            scan_byte(req_word.data_byte, req_word.last_byte, emit, outcome);
            if (emit) begin
               plan = file_outcomes.pop_front();
               pending_results.push_back(plan.typed ? plan.outcome : outcome);
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0)
               report_mismatch("result word with none expected, voxel_count",
                               rsp_word.voxel_count, 0);
            else begin
               outcome = pending_results.pop_front();
               check_field("header_ok", rsp_word.header_ok, outcome.header_ok);
               check_field("size_x", rsp_word.size_x, outcome.size_x);
               check_field("size_y", rsp_word.size_y, outcome.size_y);
               check_field("size_z", rsp_word.size_z, outcome.size_z);
               check_field("voxel_count", rsp_word.voxel_count, outcome.voxel_count);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         stall_cycles <= 0;
      else if (stall_cycles >= STALL_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else
         stall_cycles <= stall_cycles + 1;
   end

   function int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 85)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   initial begin : receiver
      rsp_ready <= 1'b0;
      while (reset !== 1'b0)
         @(posedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end else if ($urandom_range(0, 99) < 25) begin
            rsp_ready <= 1'b0;
            repeat (pick_gap() + 1) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge clock);
         end
      end
   end

   function void put_word(input logic [31:0] w);
      file_bytes.push_back(w[7:0]);
      file_bytes.push_back(w[15:8]);
      file_bytes.push_back(w[23:16]);
      file_bytes.push_back(w[31:24]);
   endfunction

   function void put_fill(input longint unsigned n);
      if (n > FILL_CAP)
         n = FILL_CAP;
      repeat (n) file_bytes.push_back(8'($urandom));
   endfunction

   function void put_size(input file_spec_type s);
      put_word(TAG_SIZE);
      put_word(s.size_clen);
      put_word(32'd0);
      put_word(s.dim_x);
      put_word(s.dim_y);
      put_word(s.dim_z);
      if (s.size_clen >= SIZE_CONTENT)
         put_fill(s.size_clen - SIZE_CONTENT);
   endfunction

   function void put_xyzi(input file_spec_type s);
      put_word(TAG_XYZI);
      put_word(s.xyzi_clen);
      put_word(32'd0);
      put_word(s.count);
      put_fill($urandom_range(0, 6));
   endfunction

   function void build_file(input file_spec_type s);
      logic [31:0] tag;
      file_bytes.delete();
      put_word(s.magic);
      put_word(s.version);
      put_word(s.main_tag);
      put_word(s.main_len);
      put_fill(s.main_len);
      if (s.pad) begin
         do tag = $urandom; while (tag == TAG_SIZE || tag == TAG_XYZI);
         put_word(tag);
         put_word(s.pad_clen);
         put_word(s.pad_child);
         put_fill(longint'(s.pad_clen) + longint'(s.pad_child));
      end
      if (s.xyzi_first)
         put_xyzi(s);
      put_size(s);
      if (s.size_twice) begin
         put_word(TAG_SIZE);
         put_word(SIZE_CONTENT);
         put_word(32'd0);
         put_fill(12);
      end
      if (!s.xyzi_first)
         put_xyzi(s);
      if (s.cut > 0)
         while (file_bytes.size() > s.cut)
            void'(file_bytes.pop_back());
   endfunction

   function logic [31:0] random_dim();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 2)
         return 32'd0;
      if (r < 4)
         return 32'(cfg_dim) + $urandom_range(1, 300);
      if (r < 5)
         return $urandom;
      return $urandom_range(1, cfg_dim);
   endfunction

   function file_spec_type random_spec();
      file_spec_type s;
      int unsigned   r;
      s = header_cases[1];
      s.typed = 1'b0;
      if ($urandom_range(0, 99) < 4)
         s.magic = TAG_VOX ^ (32'hFF << (8 * $urandom_range(0, 3)));
      r = $urandom_range(0, 99);
      if (r < 4)
         s.version = $urandom;
      else if (r < 10)
         s.version = $urandom_range(0, 1) ? $urandom_range(90, 110) : $urandom_range(240, 260);
      else
         s.version = $urandom_range(100, 250);
      if ($urandom_range(0, 99) < 3)
         s.main_tag = $urandom;
      s.main_len = ($urandom_range(0, 99) < 3) ? $urandom_range(430, 500) : $urandom_range(0, 6);
      s.pad = ($urandom_range(0, 99) < 30);
      s.pad_clen  = $urandom_range(0, 8);
      s.pad_child = $urandom_range(0, 8);
      if ($urandom_range(0, 99) < 5) begin
         s.pad_clen  = $urandom;
         s.pad_child = $urandom;
      end
      s.size_clen = ($urandom_range(0, 99) < 5) ? $urandom_range(0, 11) : 12 + $urandom_range(0, 4);
      s.dim_x = random_dim();
      s.dim_y = random_dim();
      s.dim_z = random_dim();
      s.xyzi_clen = ($urandom_range(0, 99) < 4) ? $urandom_range(0, 3) : 4 + $urandom_range(0, 4);
      r = $urandom_range(0, 99);
      if (r < 3)
         s.count = 32'(cfg_vox) + $urandom_range(1, 5000);
      else if (r < 5)
         s.count = $urandom;
      else
         s.count = $urandom_range(0, cfg_vox);
      s.xyzi_first = ($urandom_range(0, 99) < 8);
      s.size_twice = ($urandom_range(0, 99) < 10);
      s.cut = ($urandom_range(0, 99) < 10) ? $urandom_range(1, 60) : 0;
      return s;
   endfunction

   task send_byte(input req_word_type w, input int unsigned gap);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (!req_ready);
      sent_bytes++;
   endtask

   task send_file(input bit typed, input rsp_word_type outcome, input bit no_gaps);
      bit burst;
      burst = no_gaps || ($urandom_range(0, 3) == 0);
      file_outcomes.push_back('{typed, outcome});
      for (int i = 0; i < file_bytes.size(); i++)
         send_byte({file_bytes[i], i == file_bytes.size() - 1}, burst ? 0 : pick_gap());
   endtask

   task wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task write_limits(input logic [7:0] dim, input logic [15:0] vox);
      wait_drained();
      csr_wr_en <= 1'b1;
      csr_index <= CSR_MAX_DIM;
      csr_wdata <= {8'($urandom), dim};
      @(posedge clock);
      csr_index <= CSR_MAX_VOXELS;
      csr_wdata <= vox;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cfg_dim = dim;
      cfg_vox = vox;
   endtask

   initial begin : sender
      int unsigned r;
      logic [7:0]  dim;
      logic [15:0] vox;
      reset      <= 1'b1;
      req_valid  <= 1'b0;
      req_word   <= '0;
      csr_wr_en  <= 1'b0;
      csr_index  <= '0;
      csr_wdata  <= '0;
      hold_rsp   = 1'b0;
      fail_count = 0;
      sent_bytes = 0;
      cfg_dim    = MAX_DIM_RESET;
      cfg_vox    = MAX_VOXELS_RESET;
      scan_clear();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (header_cases[i]) begin
         if (header_cases[i].lim_dim != cfg_dim || header_cases[i].lim_vox != cfg_vox)
            write_limits(header_cases[i].lim_dim, header_cases[i].lim_vox);
         build_file(header_cases[i]);
         send_file(header_cases[i].typed, header_cases[i].outcome, 1'b0);
      end

      for (int n = 0; n < 16; n++) begin
         if (n % 5 == 4) begin
            r   = $urandom_range(0, 2);
            dim = (r == 0) ? 8'd1 : (r == 1) ? 8'd255 : 8'($urandom_range(1, 255));
            r   = $urandom_range(0, 3);
            vox = (r == 0) ? 16'd0 : (r == 1) ? 16'd65535 :
                  (r == 2) ? 16'($urandom_range(1, 300)) : 16'($urandom);
            write_limits(dim, vox);
         end
         if (n == 8) begin
            // stall the result side and keep short files coming
            hold_rsp = 1'b1;
            repeat (24) begin
               file_bytes.delete();
               put_fill($urandom_range(1, 3));
               send_file(1'b0, NO_HEADER, 1'b1);
            end
         end
         if ($urandom_range(0, 99) < 6) begin
            file_bytes.delete();
            put_fill($urandom_range(1, 40));
         end else
            build_file(random_spec());
         send_file(1'b0, NO_HEADER, 1'b0);
      end

      wait_drained();
      repeat (6) @(posedge clock);
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
